### rtl/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int PRIO_W   = 8;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    localparam int DATA_W   = 8;
    localparam int IPRIO_W  = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                capture;    // latch the accepted item
        logic                do_insert;  // place the held entry in order
        logic                do_remove;  // pop the head entry
        logic                load_rsp;   // latch the result fields
        logic [STATUS_W-1:0] status;
    } spq_cmd_t;

    typedef struct packed {
        logic op_remove;
        logic full;
        logic empty;
    } spq_stat_t;

endpackage

### rtl/spq_req_if.sv
interface spq_req_if
    import spq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [DATA_W-1:0]  item_data;
    logic [IPRIO_W-1:0] item_priority;

    modport source (output valid, operation, item_data, item_priority, input ready);
    modport sink   (input valid, operation, item_data, item_priority, output ready);
endinterface

### rtl/spq_rsp_if.sv
interface spq_rsp_if
    import spq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   removed_data;
    logic [IPRIO_W-1:0]  removed_priority;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, status, removed_data, removed_priority, occupancy,
                    input ready);
    modport sink   (input valid, status, removed_data, removed_priority, occupancy,
                    output ready);
endinterface

### rtl/sorted_priority_queue_top.sv
// Sorted priority queue of byte entries, each tagged with a priority.
//
// Channels: req carries one item per operation (operation 0 inserts
// item_data at item_priority, operation 1 removes the head entry);
// rsp returns exactly one item per request with status, the removed
// entry (zero unless a remove succeeded) and the occupancy afterwards.
// Entries leave in ascending priority value; equal priorities leave in
// arrival order. Insert into a full queue drops the entry and reports
// full; remove from an empty queue reports empty.
//
// Timing: req.ready is high while the controller is idle. The result
// shows on rsp once a taken request has passed the execute state;
// req.ready returns only after rsp is taken, so no new request is
// taken before the last result has left. The pace is set by the
// controller's idle / execute / respond sequence; the cell array
// shifts all entries at once, each cell comparing in parallel.
//
// Reset empties the queue at once (no clearing pass). A stalled rsp
// holds its item and blocks new requests until it is taken.
module sorted_priority_queue_top
    import spq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    spq_cmd_t  cmd;
    spq_stat_t stat;

    // Sequence each operation: capture, execute, respond.
    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Ordered cell array, entry count and result registers.
    spq_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .operation        (req.operation),
        .item_data        (req.item_data),
        .item_priority    (req.item_priority),
        .status           (rsp.status),
        .removed_data     (rsp.removed_data),
        .removed_priority (rsp.removed_priority),
        .occupancy        (rsp.occupancy)
    );

endmodule

### rtl/spq_ctrl.sv
module spq_ctrl
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  spq_stat_t stat,
    output spq_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_RESP);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.status    = STATUS_OK;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.load_rsp = 1'b1;
                if (stat.op_remove)
                begin
                    if (stat.empty)
                        cmd.status = STATUS_EMPTY;
                    else
                        cmd.do_remove = 1'b1;
                end
                else
                begin
                    if (stat.full)
                        cmd.status = STATUS_FULL;
                    else
                        cmd.do_insert = 1'b1;
                end
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (rsp_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/spq_datapath.sv
module spq_datapath
    import spq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  spq_cmd_t            cmd,
    output spq_stat_t           stat,
    input  logic                operation,
    input  logic [DATA_W-1:0]   item_data,
    input  logic [IPRIO_W-1:0]  item_priority,
    output logic [STATUS_W-1:0] status,
    output logic [DATA_W-1:0]   removed_data,
    output logic [IPRIO_W-1:0]  removed_priority,
    output logic [OCC_W-1:0]    occupancy
);

    logic [DATA_W-1:0]   data_reg [CAPACITY];
    logic [DATA_W-1:0]   data_next [CAPACITY];
    logic [PRIO_W-1:0]   prio_reg [CAPACITY];
    logic [PRIO_W-1:0]   prio_next [CAPACITY];
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;

    logic                op_reg;
    logic [DATA_W-1:0]   new_data_reg;
    logic [PRIO_W-1:0]   new_prio_reg;

    logic [STATUS_W-1:0] status_reg;
    logic [DATA_W-1:0]   rdata_reg;
    logic [IPRIO_W-1:0]  rprio_reg;
    logic [OCC_W-1:0]    occ_reg;

    // Cell holds an entry that stays ahead of the new one.
    logic [CAPACITY-1:0] keep;

    assign stat.op_remove = (op_reg == OP_REMOVE);
    assign stat.full      = (count_reg == COUNT_W'(CAPACITY));
    assign stat.empty     = (count_reg == '0);

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            keep[i] = (COUNT_W'(i) < count_reg) && (prio_reg[i] <= new_prio_reg);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            data_next[i] = data_reg[i];
            prio_next[i] = prio_reg[i];
        end
        if (cmd.do_insert)
        begin
            count_next = count_reg + COUNT_W'(1);
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (!keep[i])
                begin
                    if (i == 0 || keep[(i == 0) ? 0 : i - 1])
                    begin
                        data_next[i] = new_data_reg;
                        prio_next[i] = new_prio_reg;
                    end
                    else
                    begin
                        data_next[i] = data_reg[(i == 0) ? 0 : i - 1];
                        prio_next[i] = prio_reg[(i == 0) ? 0 : i - 1];
                    end
                end
            end
        end
        else if (cmd.do_remove)
        begin
            count_next = count_reg - COUNT_W'(1);
            for (int i = 0; i < CAPACITY - 1; i++)
            begin
                data_next[i] = data_reg[i + 1];
                prio_next[i] = prio_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            data_reg[i] <= data_next[i];
            prio_reg[i] <= prio_next[i];
        end
        if (cmd.capture)
        begin
            op_reg       <= operation;
            new_data_reg <= item_data;
            new_prio_reg <= PRIO_W'(item_priority);
        end
        if (cmd.load_rsp)
        begin
            status_reg <= cmd.status;
            occ_reg    <= OCC_W'(count_next);
            if (cmd.do_remove)
            begin
                rdata_reg <= data_reg[0];
                rprio_reg <= IPRIO_W'(prio_reg[0]);
            end
            else
            begin
                rdata_reg <= '0;
                rprio_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign status           = status_reg;
    assign removed_data     = rdata_reg;
    assign removed_priority = rprio_reg;
    assign occupancy        = occ_reg;

endmodule

### verif/spq_queue_checker.sv
module spq_queue_checker
    import spq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    spq_req_if   req,
    spq_rsp_if   rsp,
    output int   fail_count,
    output int   results_pending,
    output int   results_seen,
    output int   inserts_seen,
    output int   removes_seen,
    output int   full_seen,
    output int   empty_seen,
    output int   peak_occupancy
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 20;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data;
        logic [IPRIO_W-1:0]  prio;
        logic [OCC_W-1:0]    occupancy;
    } result_t;

    entry_t  held_entries[$];
    result_t expected_results[$];

    // Apply one operation to the shadow store and return the result it yields.
    function automatic result_t apply_op(logic op, logic [DATA_W-1:0] data,
                                         logic [IPRIO_W-1:0] prio_in);
        result_t r;
        entry_t  e;
        int      pos;
        r      = '0;
        e.data = data;
        e.prio = prio_in[PRIO_W-1:0];
        if (op == OP_INSERT) begin
            if (held_entries.size() >= CAPACITY) begin
                r.status = STATUS_FULL;
            end
            else begin
                // go behind every entry of lower or equal priority
                pos = 0;
                while (pos < held_entries.size() && held_entries[pos].prio <= e.prio)
                    pos++;
                held_entries.insert(pos, e);
            end
        end
        else begin
            if (held_entries.size() == 0) begin
                r.status = STATUS_EMPTY;
            end
            else begin
                e      = held_entries.pop_front();
                r.data = e.data;
                r.prio = IPRIO_W'(e.prio);
            end
        end
        r.occupancy = OCC_W'(held_entries.size());
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (fail_count < MAX_PRINTED)
            $display("[%0t] result %0d: %s got %0d, expected %0d",
                     $realtime, results_seen, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        result_t want;
        result_t got;
        if (!rst_n) begin
            held_entries.delete();
            expected_results.delete();
        end
        else begin
            // retire the oldest expectation first, then record the new one
            if (rsp.valid && rsp.ready) begin
                results_seen <= results_seen + 1;
                got = '{rsp.status, rsp.removed_data, rsp.removed_priority, rsp.occupancy};
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected item, status", got.status, 0);
                end
                else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.data !== want.data)
                        report_mismatch("removed_data", got.data, want.data);
                    if (got.prio !== want.prio)
                        report_mismatch("removed_priority", got.prio, want.prio);
                    if (got.occupancy !== want.occupancy)
                        report_mismatch("occupancy", got.occupancy, want.occupancy);
                end
            end
            if (req.valid && req.ready) begin
                want = apply_op(req.operation, req.item_data, req.item_priority);
                expected_results.push_back(want);
                if (req.operation == OP_INSERT) begin
                    inserts_seen <= inserts_seen + 1;
                    if (want.status == STATUS_FULL)
                        full_seen <= full_seen + 1;
                end
                else begin
                    removes_seen <= removes_seen + 1;
                    if (want.status == STATUS_EMPTY)
                        empty_seen <= empty_seen + 1;
                end
                if (held_entries.size() > peak_occupancy)
                    peak_occupancy <= held_entries.size();
            end
            results_pending <= expected_results.size();
        end
    end

endmodule

### verif/tb_sorted_priority_queue_top.sv
module tb_sorted_priority_queue_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 10;
    // spare time after the last result, to catch strays
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 600;

    logic clk = 1'b0;
    logic rst_n;

    spq_req_if req_ch();
    spq_rsp_if rsp_ch();

    int fail_count;
    int results_pending;
    int results_seen;
    int inserts_seen;
    int removes_seen;
    int full_seen;
    int empty_seen;
    int peak_occupancy;

    // percent of cycles in which the sender holds back and the receiver stalls
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int items_sent    = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    sorted_priority_queue_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    spq_queue_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .fail_count      (fail_count),
        .results_pending (results_pending),
        .results_seen    (results_seen),
        .inserts_seen    (inserts_seen),
        .removes_seen    (removes_seen),
        .full_seen       (full_seen),
        .empty_seen      (empty_seen),
        .peak_occupancy  (peak_occupancy)
    );

    // Receiver: stall at random, one decision per cycle; hold ready low in reset.
    always @(posedge clk) begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Offer one item and hold it until the block takes it. Idle cycles come
    // first so that a held valid is never dropped and raised in one step.
    task automatic issue_op(logic op, logic [DATA_W-1:0] data,
                            logic [IPRIO_W-1:0] prio);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= op;
        req_ch.item_data     <= data;
        req_ch.item_priority <= prio;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Pick a priority: mostly from narrow bands so that ties are common,
    // sometimes from the whole range, with both ends of the range well hit.
    function automatic logic [IPRIO_W-1:0] pick_priority();
        case ($urandom_range(0, 3))
            0:       return IPRIO_W'($urandom_range(0, 255));
            1:       return IPRIO_W'($urandom_range(0, 3));
            2:       return IPRIO_W'($urandom_range(252, 255));
            default: return IPRIO_W'($urandom_range(100, 103));
        endcase
    endfunction

    // Random traffic in bursts: insert-heavy bursts drive the queue to full,
    // remove-heavy bursts drain it to empty, mixed bursts churn the middle.
    task automatic run_traffic(int count);
        int  burst;
        int  remove_pct;
        int  n;
        logic op;
        n = 0;
        while (n < count) begin
            burst = $urandom_range(4, 40);
            case ($urandom_range(0, 2))
                0:       remove_pct = 15;
                1:       remove_pct = 85;
                default: remove_pct = 50;
            endcase
            for (int k = 0; k < burst && n < count; k++) begin
                op = ($urandom_range(0, 99) < remove_pct) ? OP_REMOVE : OP_INSERT;
                issue_op(op, DATA_W'($urandom_range(0, 255)), pick_priority());
                n++;
            end
        end
    endtask

    initial begin
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.operation     <= OP_INSERT;
        req_ch.item_data     <= '0;
        req_ch.item_priority <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, sender and receiver both eager.
        // Remove from the empty queue first; the payload must be ignored.
        issue_op(OP_REMOVE, 8'hFF, 8'hFF);
        // Fill to capacity with extreme and repeated priorities, so equal
        // priorities must leave in arrival order.
        for (int i = 0; i < CAPACITY; i++) begin
            case (i % 4)
                0:       issue_op(OP_INSERT, DATA_W'(i * 17), 8'h00);
                1:       issue_op(OP_INSERT, DATA_W'(i * 17), 8'hFF);
                2:       issue_op(OP_INSERT, DATA_W'(i * 17), 8'h55);
                default: issue_op(OP_INSERT, DATA_W'(i * 17), 8'hAA);
            endcase
        end
        // Insert into the full queue: dropped, flagged full.
        issue_op(OP_INSERT, 8'h5A, 8'h00);
        // Take five off the head: the four priority-zero entries in order, then the first 8'h55 one.
        repeat (5) issue_op(OP_REMOVE, 8'h00, 8'h00);

        // Random part in three idling phases.
        src_idle_pct  = 24;
        sink_idle_pct = 73;
        run_traffic(PHASE_ITEMS);
        src_idle_pct  = 73;
        sink_idle_pct = 24;
        run_traffic(PHASE_ITEMS);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_traffic(PHASE_ITEMS);
        req_ch.valid <= 1'b0;

        // Drain: wait for every result, then wait on to catch strays.
        while (results_seen < items_sent)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d operations, %0d inserts (%0d refused on a full queue),",
                 items_sent, inserts_seen, full_seen);
        $display("Summary: %0d removes (%0d on an empty queue), peak occupancy %0d of %0d",
                 removes_seen, empty_seen, peak_occupancy, CAPACITY);
        if (fail_count == 0 && results_pending == 0) begin
            $display("TB_OK");
        end
        else begin
            $display("%0d mismatches", fail_count);
            if (results_pending != 0)
                $display("%0d expected results never arrived", results_pending);
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5ms;
        $display("Watchdog expired with %0d of %0d results seen", results_seen, items_sent);
        $display("TB_ERROR");
        $finish;
    end

endmodule
